// ===== design/afcs_pkg.sv =====
// Shared types and constants for the active fault code set unit.
`default_nettype none

package afcs_pkg;

	// Default number of stored codes.
	localparam int CAPACITY_DEF = 16;

	// Command modes carried in the input transfer.
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] code;
	} in_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] code_res;
		logic [4:0]  entry_count;
		logic        any_active;
		logic        last;
	} out_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic at_end;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/afcs_ctrl.sv =====
// Controller state machine for the active fault code set unit.
`default_nettype none

module afcs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire afcs_pkg::sts_t sts,
	output logic                busy,
	output afcs_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx   = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// walk every stored entry, one read per cycle
				if (sts.at_end) begin
					state_nx = ST_FIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/afcs_dp.sv =====
// Datapath of the active fault code set unit: code memory, scan pointer, result register.
`default_nettype none

module afcs_dp #(
	parameter int CAPACITY = afcs_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire afcs_pkg::in_t  req,
	input  wire afcs_pkg::cmd_t cmd,
	output afcs_pkg::sts_t      sts,
	output afcs_pkg::out_t      result,
	output logic                strobe
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [15:0]   mem_q [CAPACITY];

	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [1:0]    mode_q;
	logic [15:0]   code_q;
	logic          found_q;

	logic          rvld_s1;
	logic [CW-1:0] ridx_s1;
	logic [15:0]   rdata_s1;

	afcs_pkg::out_t result_q;
	logic           strobe_q;

	logic          append;
	logic          remove;
	logic [CW-1:0] count_nx;
	logic          shift_we;
	logic          we;
	logic [CW-1:0] shift_addr;
	logic [IW-1:0] waddr;
	logic [15:0]   wdata;
	logic          rd_last;
	logic          is_read;

	assign is_read = (mode_q == afcs_pkg::MODE_READ);
	assign append  = (mode_q == afcs_pkg::MODE_SET) && !found_q
		&& (count_q < CW'(CAPACITY));
	assign remove  = (mode_q == afcs_pkg::MODE_CLEAR) && found_q;

	always_comb begin
		priority if (append) begin
			count_nx = count_q + CW'(1);
		end else if (remove) begin
			count_nx = count_q - CW'(1);
		end else begin
			count_nx = count_q;
		end
	end

	// after the match, move each later entry down one slot
	assign shift_we   = rvld_s1 && found_q && (mode_q == afcs_pkg::MODE_CLEAR);
	assign shift_addr = ridx_s1 - CW'(1);
	assign we         = shift_we || (cmd.finish && append);
	assign waddr      = shift_we ? shift_addr[IW-1:0] : count_q[IW-1:0];
	assign wdata      = shift_we ? rdata_s1 : code_q;
	assign rd_last    = (CW'(ridx_s1 + CW'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem_q[ptr_q[IW-1:0]];
			ridx_s1  <= ptr_q;
		end
		if (cmd.load) begin
			mode_q <= req.mode;
			code_q <= req.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= cmd.issue;
			if (cmd.load) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (rvld_s1 && !found_q && !is_read && (rdata_s1 == code_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1 && is_read) begin
			result_q.valid_res   <= 1'b1;
			result_q.code_res    <= rdata_s1;
			result_q.entry_count <= 5'(count_q);
			result_q.any_active  <= (count_q != '0);
			result_q.last        <= rd_last;
		end else if (cmd.finish) begin
			result_q.valid_res   <= 1'b0;
			result_q.code_res    <= '0;
			result_q.entry_count <= 5'(count_nx);
			result_q.any_active  <= (count_nx != '0);
			result_q.last        <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (rvld_s1 && is_read)
				|| (cmd.finish && !(is_read && (count_q != '0)));
		end
	end

	assign sts.at_end = (ptr_q == count_q);
	assign result     = result_q;
	assign strobe     = strobe_q;

	a_count_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(count_q))
		else $error("entry count changed outside finish");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (ptr_q < count_q))
		else $error("read issued past the stored entries");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !rvld_s1)
		else $error("finish while a read is still in flight");

	a_one_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rvld_s1 && is_read) |-> !cmd.finish)
		else $error("readout and status result in the same cycle");

endmodule

`default_nettype wire

// ===== design/active_fault_code_set_unit.sv =====
// Top level of the active fault code set unit.
`default_nettype none

// Ordered set of distinct active fault codes, kept in insertion order.
// Input: a command transfer happens on a rising edge with start high and busy
// low; req carries mode (clear, set, read) and code. busy stays high until the
// command is done, and no new command is taken meanwhile.
// Output: each result is on result for exactly one cycle with strobe high;
// the receiver cannot stall, so every strobe cycle is a transfer.
// Set and clear give one status result (valid_res 0, last 1) with the count
// after the update. Read gives one result per stored code, in order, on
// consecutive cycles, last on the final one; an empty list gives one invalid
// result.
// Timing: every command scans the stored entries through the single read port
// of the code memory, one entry per cycle, and busy stays high through the scan
// and the finish step. Status results appear in the first cycle with busy low;
// each readout result passes the read stage and then the result register.
// Reset: arst_n clears the count, the list is empty afterwards; the code
// memory itself is not cleared, as only entries below the count are read.
module active_fault_code_set_unit #(
	parameter int CAPACITY = afcs_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire afcs_pkg::in_t  req,
	output logic                busy,
	output afcs_pkg::out_t      result,
	output logic                strobe
);

	afcs_pkg::cmd_t cmd;
	afcs_pkg::sts_t sts;

	// sequence load, scan and finish for each command
	afcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// hold the codes, search, shift down on clear, drive the results
	afcs_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule

`default_nettype wire

// ===== bench/tb_active_fault_code_set_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the active fault code set unit: directed table, then random command sequences.
module tb_active_fault_code_set_unit;

	localparam int CAP = afcs_pkg::CAPACITY_DEF;
	// Unused fourth mode: the unit answers with a plain status transfer.
	localparam logic [1:0] MODE_NOP = 2'd3;
	// Cycles without any transfer before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Total commands to send, and the point after which the sender stops idling.
	localparam int TOTAL_ITEMS = 450;
	localparam int QUIET_FROM = 380;
	// Drain time after the last result: a full scan plus margin.
	localparam int TAIL_CYCLES = 2 * CAP + 10;

	logic           clk;
	logic           arst_n;
	logic           start;
	afcs_pkg::in_t  req;
	logic           busy;
	afcs_pkg::out_t result;
	logic           strobe;

	active_fault_code_set_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.result(result),
		.strobe(strobe)
	);

	// Directed row: the command, and where the answer is obvious, the count of
	// the single status transfer it must produce.
	typedef struct {
		afcs_pkg::in_t cmd;
		bit            typed;
		logic [4:0]    want_count;
	} row_t;

	// Shadow copy of the fault list, in insertion order.
	logic [15:0] shadow_codes [CAP];
	int unsigned shadow_count;
	// Results still owed by the unit, oldest first.
	afcs_pkg::out_t owed_results [$];

	int errors;
	int items_sent;
	int results_seen;
	int stall_cycles;
	int reads_sent;
	int full_drops;
	int shift_clears;
	int deepest_readout;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Apply one command to the shadow list and append the transfers it causes.
	task automatic predict_fault_results(input afcs_pkg::in_t cmd,
			ref afcs_pkg::out_t q[$]);
		int             pos;
		int             i;
		afcs_pkg::out_t r;
		pos = -1;
		if (cmd.mode == afcs_pkg::MODE_READ) begin
			reads_sent++;
			if (shadow_count == 0) begin
				r = '{1'b0, 16'h0000, 5'd0, 1'b0, 1'b1};
				q.push_back(r);
				return;
			end
			if (shadow_count > deepest_readout)
				deepest_readout = shadow_count;
			for (i = 0; i < shadow_count; i++) begin
				r.valid_res   = 1'b1;
				r.code_res    = shadow_codes[i];
				r.entry_count = 5'(shadow_count);
				r.any_active  = 1'b1;
				r.last        = (i == shadow_count - 1);
				q.push_back(r);
			end
			return;
		end
		for (i = 0; i < shadow_count; i++)
			if (pos < 0 && shadow_codes[i] == cmd.code)
				pos = i;
		if (cmd.mode == afcs_pkg::MODE_SET) begin
			if (pos < 0 && shadow_count < CAP) begin
				shadow_codes[shadow_count] = cmd.code;
				shadow_count++;
			end else if (pos < 0) begin
				full_drops++;
			end
		end else if (cmd.mode == afcs_pkg::MODE_CLEAR && pos >= 0) begin
			// Close the gap: later entries move down one slot.
			for (i = pos; i + 1 < shadow_count; i++)
				shadow_codes[i] = shadow_codes[i + 1];
			if (pos + 1 < shadow_count)
				shift_clears++;
			shadow_count--;
			shadow_codes[shadow_count] = 16'h0000;
		end
		r = '{1'b0, 16'h0000, 5'(shadow_count), shadow_count != 0, 1'b1};
		q.push_back(r);
	endtask

	// Hold start and the command until the unit takes it, then record what it owes.
	task automatic send_command(input afcs_pkg::in_t cmd, input bit typed,
			input logic [4:0] want_count);
		afcs_pkg::out_t scratch [$];
		afcs_pkg::out_t want;
		start <= 1'b1;
		req   <= cmd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (typed) begin
			// Keep the shadow list in step but expect the typed-in answer.
			predict_fault_results(cmd, scratch);
			want = '{1'b0, 16'h0000, want_count, want_count != 0, 1'b1};
			owed_results.push_back(want);
		end else begin
			predict_fault_results(cmd, owed_results);
		end
	endtask

	// Drop start for a random burst, but only in the early part of the run.
	task automatic maybe_idle();
		if (items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// Hold the sender off until every owed transfer has arrived.
	task automatic drain_results();
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic row_t mk_row(input logic [1:0] m, input logic [15:0] c, input bit t,
			input int n);
		row_t row;
		row.cmd.mode  = m;
		row.cmd.code  = c;
		row.typed     = t;
		row.want_count = 5'(n);
		return row;
	endfunction

	// Check every strobe cycle against the oldest owed transfer, field by field.
	always @(posedge clk) begin
		afcs_pkg::out_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed: %p", result));
			end else begin
				want = owed_results.pop_front();
				if (result.valid_res !== want.valid_res)
					report_mismatch($sformatf("valid_res %b, want %b",
						result.valid_res, want.valid_res));
				if (result.code_res !== want.code_res)
					report_mismatch($sformatf("code_res %h, want %h",
						result.code_res, want.code_res));
				if (result.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						result.entry_count, want.entry_count));
				if (result.any_active !== want.any_active)
					report_mismatch($sformatf("any_active %b, want %b",
						result.any_active, want.any_active));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %b, want %b", result.last, want.last));
			end
		end
	end

	// Hang detector: any command or result transfer resets the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d results owed",
				STALL_LIMIT, owed_results.size());
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		row_t          directed_rows [$];
		afcs_pkg::in_t cmd;
		logic [15:0]   pool [$];
		int            seg;
		int            seg_len;
		int            set_weight;
		int            pick;
		int            k;
		int            i;

		errors = 0;
		items_sent = 0;
		results_seen = 0;
		stall_cycles = 0;
		reads_sent = 0;
		full_drops = 0;
		shift_clears = 0;
		deepest_readout = 0;
		shadow_count = 0;
		for (i = 0; i < CAP; i++)
			shadow_codes[i] = 16'h0000;

		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, extreme codes, duplicates, misses,
		// removal at head, middle and tail, the unused mode.
		directed_rows.push_back(mk_row(afcs_pkg::MODE_READ,  16'h0000, 1, 0));  // empty list
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'h1234, 1, 0));  // absent code
		directed_rows.push_back(mk_row(MODE_NOP,             16'hFFFF, 1, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_SET,   16'hFFFF, 1, 1));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_SET,   16'h0000, 1, 2));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_SET,   16'hFFFF, 1, 2));  // present
		directed_rows.push_back(mk_row(afcs_pkg::MODE_SET,   16'h8001, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_SET,   16'h7FFE, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_READ,  16'hFFFF, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'h0000, 0, 0));  // middle
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'h0000, 1, 3));  // now absent
		directed_rows.push_back(mk_row(afcs_pkg::MODE_READ,  16'h5A5A, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'hFFFF, 0, 0));  // head
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'h7FFE, 0, 0));  // tail
		directed_rows.push_back(mk_row(MODE_NOP,             16'h0000, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_READ,  16'hA5A5, 0, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_CLEAR, 16'h8001, 1, 0));
		directed_rows.push_back(mk_row(afcs_pkg::MODE_READ,  16'h0000, 1, 0));
		foreach (directed_rows[r]) begin
			send_command(directed_rows[r].cmd, directed_rows[r].typed,
				directed_rows[r].want_count);
			maybe_idle();
		end
		drain_results();

		// Random part, in segments. Every fourth segment fills the list to
		// capacity and pushes past it; the rest mix commands over a small
		// pool of codes so duplicates, misses and mid-list removals are common.
		for (seg = 0; items_sent < TOTAL_ITEMS; seg++) begin
			if (seg % 4 == 0) begin
				while (shadow_count < CAP && items_sent < TOTAL_ITEMS) begin
					cmd.mode = afcs_pkg::MODE_SET;
					cmd.code = 16'($urandom);
					send_command(cmd, 0, 5'd0);
					maybe_idle();
				end
				// Set on a full list, both a new code and a stored one.
				cmd.mode = afcs_pkg::MODE_SET;
				cmd.code = 16'($urandom);
				send_command(cmd, 0, 5'd0);
				cmd.code = shadow_codes[$urandom_range(0, CAP - 1)];
				send_command(cmd, 0, 5'd0);
				cmd.mode = afcs_pkg::MODE_READ;
				send_command(cmd, 0, 5'd0);
				maybe_idle();
				cmd.mode = afcs_pkg::MODE_CLEAR;
				cmd.code = shadow_codes[$urandom_range(0, shadow_count - 1)];
				send_command(cmd, 0, 5'd0);
				cmd.mode = afcs_pkg::MODE_READ;
				cmd.code = 16'($urandom);
				send_command(cmd, 0, 5'd0);
				maybe_idle();
			end else begin
				pool.delete();
				repeat ($urandom_range(2, 24))
					pool.push_back(16'($urandom));
				seg_len = $urandom_range(15, 40);
				set_weight = $urandom_range(30, 60);
				for (k = 0; k < seg_len && items_sent < TOTAL_ITEMS; k++) begin
					pick = $urandom_range(0, 99);
					cmd.code = pool[$urandom_range(0, pool.size() - 1)];
					if (pick < 12) begin
						cmd.mode = afcs_pkg::MODE_READ;
						cmd.code = 16'($urandom);
					end else if (pick < 15) begin
						cmd.mode = MODE_NOP;
						cmd.code = 16'($urandom);
					end else if (pick < 15 + set_weight) begin
						cmd.mode = afcs_pkg::MODE_SET;
						if ($urandom_range(0, 19) == 0)
							cmd.code = 16'($urandom);
					end else begin
						cmd.mode = afcs_pkg::MODE_CLEAR;
						// Mostly hit a stored entry, anywhere in the list.
						if (shadow_count > 0 && $urandom_range(0, 2) != 0)
							cmd.code = shadow_codes[$urandom_range(0, shadow_count - 1)];
						else if ($urandom_range(0, 3) == 0)
							cmd.code = 16'($urandom);
					end
					send_command(cmd, 0, 5'd0);
					maybe_idle();
				end
			end
			if (seg % 3 == 2 && items_sent < QUIET_FROM)
				drain_results();
		end

		// Wind down: no new commands, collect what is owed, then watch for strays.
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("run: %0d commands (%0d reads, deepest readout %0d codes), %0d results checked",
			items_sent, reads_sent, deepest_readout, results_seen);
		$display("run: %0d sets dropped on a full list, %0d clears shifted later entries down",
			full_drops, shift_clears);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
design/afcs_pkg.sv
design/afcs_ctrl.sv
design/afcs_dp.sv
design/active_fault_code_set_unit.sv
bench/tb_active_fault_code_set_unit.sv
